/* hw/rtl/rle8_pkg.sv */
// Shared constants and helpers for the RLE8 bitmap stream decoder.
package rle8_pkg;

   // Largest usable row width; the configured width is limited to this.
   localparam int MAX_WIDTH = 2048;

   localparam int BYTE_W   = 8;
   localparam int COL_W    = 12;
   localparam int ROW_W    = 12;
   localparam int OCOL_W   = 11;
   localparam int KIND_W   = 2;
   localparam int PHASE_W  = 3;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COL_W-1:0]   col_type;
   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [OCOL_W-1:0]  ocol_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [PHASE_W-1:0] phase_type;

   // Result kinds
   localparam kind_type KIND_RUN = 2'd0;
   localparam kind_type KIND_EOL = 2'd1;
   localparam kind_type KIND_EOB = 2'd2;

   // Escape codes following a zero first byte
   localparam byte_type ESC_EOL   = 8'h00;
   localparam byte_type ESC_EOB   = 8'h01;
   localparam byte_type ESC_DELTA = 8'h02;

   // Parser phases
   localparam phase_type PH_FIRST  = 3'd0;
   localparam phase_type PH_SECOND = 3'd1;
   localparam phase_type PH_DX     = 3'd2;
   localparam phase_type PH_DY     = 3'd3;
   localparam phase_type PH_LIT    = 3'd4;
   localparam phase_type PH_PAD    = 3'd5;

   localparam col_type  ROW_WIDTH_RESET = 12'd480;
   localparam col_type  COL_MAX         = {COL_W{1'b1}};
   localparam ocol_type OCOL_MAX        = {OCOL_W{1'b1}};

   // Column plus a byte, saturating at the top of the column range.
   function automatic col_type add_column(input col_type col, input byte_type n);
      logic [COL_W:0] sum;
      begin
         sum = {1'b0, col} + {{(COL_W+1-BYTE_W){1'b0}}, n};
         add_column = sum[COL_W] ? COL_MAX : sum[COL_W-1:0];
      end
   endfunction

endpackage

/* hw/rtl/rle8_bitmap_decoder.sv */
// RLE8 bitmap stream decoder: byte parser with registered input and result stages.
//
// Usage:
//   req_ channel carries one compressed stream byte per word (req_stream_byte).
//   rsp_ channel carries at most one result per input byte: a pixel run
//   (column, clipped length, palette index, row), an end of line or an end of
//   bitmap marker. Bytes that only move the parser (first byte of a command,
//   escape bytes of a delta, pad bytes, literal counts) produce no word.
//   csr_wr_en / csr_wr_data set the row width; write only while idle.
// Timing:
//   A byte is registered into the input stage on acceptance, parsed there,
//   and its result is registered into the result stage when it advances.
//   One byte is accepted every cycle while req_stall is low; the rate is set
//   by the single parse stage, whose state update is one short step per byte.
// Reset (synchronous, active high) empties both stages, returns the parser to
//   the first byte of a command, clears column and row, and sets the row
//   width to 480.
// Stall: while rsp_stall holds a valid result, the result stage holds; an
//   empty input stage still fills, and req_stall rises once it is occupied.
module rle8_bitmap_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  rle8_pkg::col_type   csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  rle8_pkg::byte_type  req_stream_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rle8_pkg::kind_type  rsp_kind,
   output rle8_pkg::ocol_type  rsp_run_column,
   output rle8_pkg::byte_type  rsp_run_length,
   output rle8_pkg::byte_type  rsp_pixel_index,
   output rle8_pkg::row_type   rsp_row_number,
   output logic                rsp_clipped
);
   import rle8_pkg::*;

   localparam logic [COL_W:0] MAX_WIDTH_W = (COL_W+1)'(MAX_WIDTH);

   // configuration
   col_type   row_width_ff;

   // input stage
   logic      in_valid_ff;
   byte_type  in_byte_ff;

   // parser state
   phase_type phase_ff, phase_in;
   byte_type  held_ff, held_in;
   byte_type  lits_ff, lits_in;
   logic      pad_ff, pad_in;
   col_type   column_ff, column_in;
   row_type   row_ff, row_in;

   // result stage
   logic      rsp_valid_ff;
   kind_type  kind_ff, kind_in;
   ocol_type  ocol_ff, ocol_in;
   byte_type  len_ff, len_in;
   byte_type  pix_ff, pix_in;
   row_type   orow_ff, orow_in;
   logic      clip_ff, clip_in;
   logic      emit;

   logic      advance;
   col_type   width_eff;
   col_type   room;
   byte_type  run_len;
   byte_type  run_pix;
   byte_type  lits_dec;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   assign width_eff = ({1'b0, row_width_ff} > MAX_WIDTH_W) ? MAX_WIDTH_W[COL_W-1:0]
                                                           : row_width_ff;
   assign room      = width_eff - column_ff;
   assign lits_dec  = lits_ff - 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      lits_in   = lits_ff;
      pad_in    = pad_ff;
      column_in = column_ff;
      row_in    = row_ff;
      emit      = 1'b0;
      kind_in   = KIND_RUN;
      ocol_in   = '0;
      len_in    = '0;
      pix_in    = '0;
      orow_in   = row_ff;
      clip_in   = 1'b0;
      run_len   = '0;
      run_pix   = in_byte_ff;

      case (phase_ff)
         PH_SECOND: begin
            phase_in = PH_FIRST;
            if (held_ff != 8'd0) begin
               emit    = 1'b1;
               run_len = held_ff;
            end else if (in_byte_ff == ESC_EOL) begin
               emit      = 1'b1;
               kind_in   = KIND_EOL;
               column_in = '0;
               row_in    = row_ff + 12'd1;
            end else if (in_byte_ff == ESC_EOB) begin
               emit      = 1'b1;
               kind_in   = KIND_EOB;
               column_in = '0;
               row_in    = '0;
            end else if (in_byte_ff == ESC_DELTA) begin
               phase_in = PH_DX;
            end else begin
               lits_in  = in_byte_ff;
               pad_in   = in_byte_ff[0];
               phase_in = PH_LIT;
            end
         end
         PH_DX: begin
            column_in = add_column(column_ff, in_byte_ff);
            phase_in  = PH_DY;
         end
         PH_DY: begin
            phase_in = PH_FIRST;
         end
         PH_LIT: begin
            emit    = 1'b1;
            run_len = 8'd1;
            lits_in = lits_dec;
            if (lits_dec == 8'd0) begin
               phase_in = pad_ff ? PH_PAD : PH_FIRST;
            end
         end
         PH_PAD: begin
            pad_in   = 1'b0;
            phase_in = PH_FIRST;
         end
         default: begin
            held_in  = in_byte_ff;
            phase_in = PH_SECOND;
         end
      endcase

      // pixel run: clip against the effective width, then advance the column
      if (emit && kind_in == KIND_RUN) begin
         pix_in  = run_pix;
         ocol_in = (column_ff > {1'b0, OCOL_MAX}) ? OCOL_MAX : column_ff[OCOL_W-1:0];
         if (column_ff >= width_eff) begin
            len_in  = '0;
            clip_in = 1'b1;
         end else if ({{(COL_W-BYTE_W){1'b0}}, run_len} > room) begin
            len_in  = room[BYTE_W-1:0];
            clip_in = 1'b1;
         end else begin
            len_in = run_len;
         end
         column_in = add_column(column_ff, run_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_FIRST;
         held_ff      <= '0;
         lits_ff      <= '0;
         pad_ff       <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            row_width_ff <= csr_wr_data;
         end
         // fill the input stage whenever it is not held
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff && emit;
            // drop the parser update when the input stage is empty
            if (in_valid_ff) begin
               phase_ff  <= phase_in;
               held_ff   <= held_in;
               lits_ff   <= lits_in;
               pad_ff    <= pad_in;
               column_ff <= column_in;
               row_ff    <= row_in;
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_stream_byte;
      end
      if (advance) begin
         kind_ff    <= kind_in;
         ocol_ff    <= ocol_in;
         len_ff     <= len_in;
         pix_ff     <= pix_in;
         orow_ff    <= orow_in;
         clip_ff    <= clip_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_run_column  = ocol_ff;
   assign rsp_run_length  = len_ff;
   assign rsp_pixel_index = pix_ff;
   assign rsp_row_number  = orow_ff;
   assign rsp_clipped     = clip_ff;

endmodule

/* hw/rtl/rle8_checker.sv */
// Port-level checks for the RLE8 bitmap stream decoder, bound to the top level.
module rle8_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rle8_pkg::kind_type  rsp_kind,
   input rle8_pkg::ocol_type  rsp_run_column,
   input rle8_pkg::byte_type  rsp_run_length,
   input rle8_pkg::byte_type  rsp_pixel_index,
   input rle8_pkg::row_type   rsp_row_number,
   input logic                rsp_clipped
);
   import rle8_pkg::*;

   logic after_eob_ff;

   // track whether the last delivered word was an end of bitmap
   always_ff @(posedge clock) begin
      if (reset) begin
         after_eob_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         after_eob_ff <= (rsp_kind == KIND_EOB);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_row_number))
      else $error("stalled result word changed");

   a_marker_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_RUN |->
         rsp_run_length == 8'd0 && rsp_clipped == 1'b0 &&
         rsp_run_column == '0 && rsp_pixel_index == 8'd0)
      else $error("line or bitmap marker carries run fields");

   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && after_eob_ff |-> rsp_row_number == '0)
      else $error("row not restarted after end of bitmap");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty result stage");

endmodule

bind rle8_bitmap_decoder rle8_checker u_rle8_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_run_column  (rsp_run_column),
   .rsp_run_length  (rsp_run_length),
   .rsp_pixel_index (rsp_pixel_index),
   .rsp_row_number  (rsp_row_number),
   .rsp_clipped     (rsp_clipped)
);
